### src/ftwb_pkg.sv
`default_nettype none
package ftwb_pkg;

  typedef enum logic [1:0] {
    REQ_PACKET = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_SWEEP  = 2'd3
  } req_e;

  localparam logic [2:0] CFG_LINK_COUNT = 3'd0;
  localparam logic [2:0] CFG_WINDOW0    = 3'd1;
  localparam logic [2:0] CFG_WINDOW3    = 3'd4;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd5;

  localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

  localparam int unsigned KEY_W = 104;

  // stored entry with its valid bit
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [31:0]      bytes;
    logic [1:0]       link;
    logic [31:0]      seen_sec;
  } entry_t;

endpackage
`default_nettype wire

### src/ftwb_mixer.sv
`default_nettype none
// iterative hash: one 32x32 multiplier, used on the two multiply steps
module ftwb_mixer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] seed_i,
  output logic             done_o,
  output logic [31:0]      hash_o
);
  logic [31:0] h_q, h_d;
  logic [2:0]  step_q, step_d;
  logic [31:0] mul_a, mul_b, prod;

  always_comb begin
    mul_a = h_q;
    mul_b = (step_q == 3'd1) ? ftwb_pkg::MIX_C1 : ftwb_pkg::MIX_C2;
    prod  = mul_a * mul_b;
    h_d    = h_q;
    step_d = step_q;
    if (start_i) begin
      h_d    = seed_i ^ (seed_i >> 16);
      step_d = 3'd1;
    end else begin
      case (step_q)
        3'd1: begin h_d = prod;                step_d = 3'd2; end
        3'd2: begin h_d = h_q ^ (h_q >> 13);   step_d = 3'd3; end
        3'd3: begin h_d = prod;                step_d = 3'd4; end
        3'd4: begin h_d = h_q ^ (h_q >> 16);   step_d = 3'd5; end
        default: step_d = 3'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 3'd0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign done_o = (step_q == 3'd5);
  assign hash_o = h_q;
endmodule
`default_nettype wire

### src/flow_table_wan_balancer_top.sv
`default_nettype none
// packet and add-bytes words: hash, bucket base, then a read request and a check per way until
//   a hit or the last way, then the action step, plus a credit update on a hit
// tick: goes straight to the result step; sweep: a read request and an expiry check per slot
// one word at a time; the next word can be taken in the cycle after the result is taken
// after reset a pass over BUCKETS*WAYS slots, one per cycle, clears the table first
// registers reset to zero, idle_timeout to 30 and the state to the clear pass
module flow_table_wan_balancer_top #(
  parameter int unsigned BUCKETS   = 1024,
  parameter int unsigned WAYS      = 4,
  parameter int unsigned MAX_LINKS = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type, source_address, dest_address, source_port_num, dest_port_num,
  // proto_num, byte_len, zero fill
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // link_index, flow_found, table_full, removed_count, zero fill
  output logic [23:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_addr_i,
  input  wire logic [31:0]  cfg_wdata_i
);
  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b00000000001,
    ST_IDLE  = 11'b00000000010,
    ST_HASH  = 11'b00000000100,
    ST_RDREQ = 11'b00000001000,
    ST_RDCHK = 11'b00000010000,
    ST_ACT   = 11'b00000100000,
    ST_CRED  = 11'b00001000000,
    ST_SWRQ  = 11'b00010000000,
    ST_SWCK  = 11'b00100000000,
    ST_OUT   = 11'b01000000000,
    ST_BASE  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [2:0]  link_count_q;
  logic [31:0] window_q [4];
  logic [15:0] timeout_q;
  logic [1:0]  rr_q;
  logic [31:0] now_q;

  ftwb_pkg::entry_t mem [SLOTS];
  ftwb_pkg::entry_t rd_q;
  logic             mem_we;
  logic [SW-1:0]    mem_wa;
  ftwb_pkg::entry_t mem_wd;
  logic [SW-1:0]    rd_addr;

  logic [1:0]  type_q;
  logic [103:0] key_q;
  logic [15:0] len_q;
  logic [SW-1:0] base_q, slot_q, hit_q, free_q;
  logic [WW:0] way_q;
  logic found_q, have_free_q;
  logic [12:0] removed_q;
  logic [1:0]  link_res_q;
  logic full_q;
  logic [23:0] out_q;
  logic out_v_q;

  logic        mix_start, mix_done;
  logic [31:0] hash;

  logic [2:0] n_links;
  assign n_links = (link_count_q > 3'(MAX_LINKS)) ? 3'(MAX_LINKS) : link_count_q;

  logic [31:0] seed;
  assign seed = s_axis_tdata[33:2] ^ s_axis_tdata[65:34] ^
                {s_axis_tdata[81:66], s_axis_tdata[97:82]} ^ {24'd0, s_axis_tdata[105:98]};

  assign mix_start = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tdata[1:0] == ftwb_pkg::REQ_PACKET ||
                      s_axis_tdata[1:0] == ftwb_pkg::REQ_ADD);

  ftwb_mixer u_mixer (
    .clk_i, .rst_ni, .start_i(mix_start), .seed_i(seed),
    .done_o(mix_done), .hash_o(hash)
  );

  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr];
  end

  // credit arithmetic on the way read back
  logic [31:0] sum;
  logic [31:0] limit;
  logic        rotate;
  logic [2:0]  nxt;
  always_comb begin
    sum = rd_q.bytes + {16'd0, len_q};
    limit = ({1'b0, rd_q.link} < n_links) ? window_q[rd_q.link] : 32'd0;
    rotate = (limit != 32'd0) && (sum >= limit);
    nxt = {1'b0, rd_q.link} + 3'd1;
    if (nxt >= n_links) nxt = 3'd0;
  end

  logic [31:0] idle;
  assign idle = now_q - rd_q.seen_sec;

  logic expired;
  assign expired = rd_q.valid && (idle > {16'd0, timeout_q});

  // round robin pointer reduced modulo the links in use
  logic [2:0] rr_link, rr_next;
  always_comb begin
    rr_link = {1'b0, rr_q};
    if (n_links <= 3'd1) rr_link = 3'd0;
    else if ({1'b0, rr_q} >= n_links) rr_link = {1'b0, rr_q} - n_links;
    rr_next = rr_link + 3'd1;
    if (rr_next >= n_links) rr_next = 3'd0;
  end

  always_comb begin
    state_d = state_q;
    mem_we = 1'b0;
    mem_wa = slot_q;
    mem_wd = rd_q;
    rd_addr = slot_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wd = '0;
        if (slot_q == SW'(SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          case (s_axis_tdata[1:0])
            ftwb_pkg::REQ_TICK:  state_d = ST_OUT;
            ftwb_pkg::REQ_SWEEP: state_d = ST_SWRQ;
            default:             state_d = ST_HASH;
          endcase
        end
      end
      ST_HASH:  if (mix_done) state_d = ST_BASE;
      ST_BASE:  state_d = ST_RDREQ;
      ST_RDREQ: state_d = ST_RDCHK;
      ST_RDCHK: begin
        if ((rd_q.valid && rd_q.key == key_q) || way_q == (WW+1)'(WAYS - 1)) state_d = ST_ACT;
        else state_d = ST_RDREQ;
      end
      ST_ACT: begin
        rd_addr = hit_q;
        if (found_q) state_d = ST_CRED;
        else begin
          state_d = ST_OUT;
          if (type_q == ftwb_pkg::REQ_PACKET && have_free_q) begin
            mem_we = 1'b1;
            mem_wa = free_q;
            mem_wd.valid = 1'b1;
            mem_wd.key = key_q;
            mem_wd.bytes = {16'd0, len_q};
            mem_wd.link = rr_link[1:0];
            mem_wd.seen_sec = now_q;
          end
        end
      end
      ST_CRED: begin
        mem_we = 1'b1;
        mem_wa = hit_q;
        mem_wd.bytes = rotate ? 32'd0 : sum;
        mem_wd.link = rotate ? nxt[1:0] : rd_q.link;
        if (type_q == ftwb_pkg::REQ_PACKET) mem_wd.seen_sec = now_q;
        state_d = ST_OUT;
      end
      ST_SWRQ: state_d = ST_SWCK;
      ST_SWCK: begin
        if (expired) begin
          mem_we = 1'b1;
          mem_wd.valid = 1'b0;
        end
        state_d = (slot_q == SW'(SLOTS - 1)) ? ST_OUT : ST_SWRQ;
      end
      ST_OUT:  if (!out_v_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      slot_q <= '0;
      link_count_q <= '0;
      for (int i = 0; i < 4; i++) window_q[i] <= '0;
      timeout_q <= 16'd30;
      rr_q <= '0;
      now_q <= '0;
      out_v_q <= 1'b0;
      out_q <= '0;
      type_q <= '0;
      key_q <= '0;
      len_q <= '0;
      base_q <= '0;
      hit_q <= '0;
      free_q <= '0;
      way_q <= '0;
      found_q <= 1'b0;
      have_free_q <= 1'b0;
      removed_q <= '0;
      link_res_q <= '0;
      full_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ftwb_pkg::CFG_LINK_COUNT: link_count_q <= cfg_wdata_i[2:0];
          ftwb_pkg::CFG_TIMEOUT:    timeout_q <= cfg_wdata_i[15:0];
          default: begin
            if (cfg_addr_i >= ftwb_pkg::CFG_WINDOW0 && cfg_addr_i <= ftwb_pkg::CFG_WINDOW3)
              window_q[2'(cfg_addr_i - ftwb_pkg::CFG_WINDOW0)] <= cfg_wdata_i;
          end
        endcase
      end
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      case (state_q)
        ST_CLEAR: slot_q <= slot_q + SW'(1);
        ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            type_q <= s_axis_tdata[1:0];
            key_q <= s_axis_tdata[105:2];
            len_q <= s_axis_tdata[121:106];
            found_q <= 1'b0;
            have_free_q <= 1'b0;
            full_q <= 1'b0;
            link_res_q <= '0;
            removed_q <= '0;
            way_q <= '0;
            slot_q <= '0;
            if (s_axis_tdata[1:0] == ftwb_pkg::REQ_TICK) now_q <= now_q + 32'd1;
          end
        end
        ST_BASE: begin
          base_q <= SW'(32'(hash % BUCKETS) * WAYS);
          slot_q <= SW'(32'(hash % BUCKETS) * WAYS);
        end
        ST_RDREQ: ;
        ST_RDCHK: begin
          if (rd_q.valid) begin
            if (rd_q.key == key_q) begin
              found_q <= 1'b1;
              hit_q <= slot_q;
            end
          end else if (!have_free_q) begin
            have_free_q <= 1'b1;
            free_q <= slot_q;
          end
          way_q <= way_q + (WW+1)'(1);
          slot_q <= slot_q + SW'(1);
        end
        ST_ACT: begin
          if (!found_q && type_q == ftwb_pkg::REQ_PACKET) begin
            if (!have_free_q) full_q <= 1'b1;
            else if (n_links != 3'd0) begin
              link_res_q <= rr_link[1:0];
              rr_q <= rr_next[1:0];
            end
          end
        end
        ST_CRED: link_res_q <= rotate ? nxt[1:0] : rd_q.link;
        ST_SWCK: begin
          if (expired) begin
            if (removed_q != 13'h1fff) removed_q <= removed_q + 13'd1;
          end
          slot_q <= slot_q + SW'(1);
        end
        ST_OUT: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
            out_q <= {7'd0, removed_q, full_q, found_q, link_res_q};
          end
        end
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = ^{base_q, s_axis_tdata[127:122]};
endmodule
`default_nettype wire

### src/ftwb_checker.sv
`default_nettype none
module ftwb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input open with result pending");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2] && m_axis_tdata[1:0] == 2'd0)
    else $error("full with link");
endmodule

bind flow_table_wan_balancer_top ftwb_checker u_ftwb_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
